// File: rtl/tlj_pkg.sv
// package for the text line justifier: constants, register address, sequencer states
// no dependencies
package tlj_pkg;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PREP  = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_WORD  = 9'b000001000,
    ST_OUT   = 9'b000010000,
    ST_SPACE = 9'b000100000,
    ST_PAD   = 9'b001000000,
    ST_LAST  = 9'b010000000,
    ST_APPND = 9'b100000000
  } state_t;
endpackage

// File: rtl/tlj_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module tlj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/text_line_justifier.sv
// text_line_justifier top level: greedy full justification of a character stream
// depends on tlj_pkg and tlj_ram
//
// Characters come in on the s_axis side: tdata = character, tlast = word_end,
// tuser = text_end (a text end also ends its word). Characters of a word go into a
// word ram; a word longer than the line width keeps only its first line width
// bytes and marks the line as truncated. At a word end the word is copied into the
// line ram one byte a cycle, after the held line has been emitted if the word no
// longer fits (or the line already holds (MAX_WIDTH+1)/2 words). Emitting a full
// line with two or more words and room for a space in each gap first runs a
// restoring divider (one quotient bit a cycle) to split the padding over the gaps;
// then a small sequencer walks words, gaps and padding through one registered
// output stage: per word character a line ram read, then the output; spaces go
// straight to the output, and the m_axis side stalls this while tready is low. A
// byte that is not a word end is only accepted; a word end is accepted, copied
// into the line ram and booked into the line. Emitting a line runs a set-up
// step, the divider where used, the characters and spaces, then a clearing step.
// s_axis tready is low whenever the block is not idle. m_axis tdata = out_char,
// tuser = {final_line, word_truncated} from bit 0 up, tlast = line_end. Register
// line_width sits at byte address 0.
module text_line_justifier
  import tlj_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // character[7:0]
  input  logic        s_axis_tlast,   // word_end
  input  logic        s_axis_tuser,   // text_end[0]
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [7:0]  m_axis_tdata,   // out_char[7:0]
  output logic [1:0]  m_axis_tuser,   // final_line[0], word_truncated[1]
  output logic        m_axis_tlast,   // line_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WORDS_MAX = (MAX_WIDTH + 1) / 2;
  localparam int NW = $clog2(WORDS_MAX + 1);
  localparam int LW = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int CW = 6;

  logic [5:0] line_width;
  logic [CW-1:0] w_eff;
  state_t state;

  // line state
  logic [CW-1:0] chars_in_line, cur_len;
  logic [NW-1:0] words_in_line;
  logic trunc_seen, word_cut;
  logic [CW-1:0] lens [WORDS_MAX];
  logic pend_last;

  // sequencer
  logic [CW-1:0] pos, k, cnt;
  logic [NW-1:0] widx;
  logic [CW-1:0] quo, rem, dvd, dvr, rpart;
  logic [2:0] dstep;
  logic last_mode, lone;
  logic rd_pend;

  // output stage
  logic       ovalid;
  logic [7:0] ochar;
  logic       oend, ofinal, otrunc;

  // rams
  logic          wr_we, ln_we;
  logic [AW-1:0] wr_waddr, wr_raddr, ln_waddr, ln_raddr;
  logic [7:0]    wr_wdata, wr_rdata, ln_rdata;

  tlj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_word (
    .clk, .we(wr_we), .waddr(wr_waddr), .wdata(wr_wdata),
    .raddr(wr_raddr), .rdata(wr_rdata));
  tlj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
    .clk, .we(ln_we), .waddr(ln_waddr), .wdata(wr_rdata),
    .raddr(ln_raddr), .rdata(ln_rdata));

  assign pready = 1'b1;
  assign prdata = {26'd0, line_width};
  assign w_eff = (line_width == 6'd0) ? 6'd1 :
                 (line_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : line_width;

  logic in_acc, out_free;
  logic [7:0] in_char;
  logic in_we, in_te;
  assign in_char = s_axis_tdata;
  assign in_te   = s_axis_tuser;
  assign in_we   = s_axis_tlast | in_te;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid || m_axis_tready;

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = ochar;
  assign m_axis_tuser  = {otrunc, ofinal};
  assign m_axis_tlast  = oend;

  logic store_ok;
  assign store_ok = (cur_len < w_eff) && (cur_len < 6'(MAX_WIDTH));
  assign wr_we    = in_acc && store_ok;
  assign wr_waddr = cur_len[AW-1:0];
  assign wr_wdata = in_char;

  // fit check at a word end, using the length after this byte
  logic [CW-1:0] new_len;
  logic [7:0] need;
  logic overflow;
  assign new_len = store_ok ? cur_len + 6'd1 : cur_len;
  assign need = 8'(chars_in_line) + 8'(new_len) + 8'(words_in_line);
  assign overflow = (words_in_line != '0) &&
                    ((need > 8'(w_eff)) || (words_in_line >= NW'(WORDS_MAX)));

  // current word in the sequencer
  logic [CW-1:0] cur_wlen, room;
  logic [NW-1:0] gaps;
  logic word_done, line_done;
  assign cur_wlen  = lens[widx[LW-1:0]];
  assign gaps      = words_in_line - NW'(1);
  assign room      = w_eff - chars_in_line;
  assign word_done = (k + 6'd1) == cur_wlen;
  assign line_done = word_done && (widx == gaps);

  // copy of word ram into line ram, one byte a cycle with a read delay
  assign wr_raddr = k[AW-1:0];
  assign ln_we    = (state == ST_APPND) && rd_pend;
  assign ln_waddr = AW'(chars_in_line + k - 6'd1);
  assign ln_raddr = pos[AW-1:0];

  // restoring divider step
  logic [CW:0] diff;
  logic [CW-1:0] rp_next, q_next;
  assign diff    = {rpart, dvd[CW-1]} - {1'b0, dvr};
  assign rp_next = diff[CW] ? {rpart[CW-2:0], dvd[CW-1]} : diff[CW-1:0];
  assign q_next  = {quo[CW-2:0], !diff[CW]};

  // output character transfer into the output register
  logic emit, emit_end, emit_final;
  assign emit = out_free &&
                (state == ST_OUT || state == ST_SPACE || state == ST_PAD);
  assign emit_end = (state == ST_OUT) ? (line_done && !(lone && cnt != '0)) :
                    ((state == ST_PAD) && (cnt == 6'd1));
  assign emit_final = (state == ST_OUT) && line_done && last_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit) begin
      ovalid <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid <= 1'b0;
    end
    if (emit) begin
      ochar  <= (state == ST_OUT) ? ln_rdata : SPACE_CHAR;
      oend   <= emit_end;
      ofinal <= emit_final;
      otrunc <= trunc_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 6'd32;
      state <= ST_IDLE;
      chars_in_line <= '0;
      words_in_line <= '0;
      cur_len <= '0;
      trunc_seen <= 1'b0;
      word_cut <= 1'b0;
      rd_pend <= 1'b0;
      pend_last <= 1'b0;
      last_mode <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_LINE_WIDTH) begin
        line_width <= pwdata[5:0];
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cur_len <= new_len;
            if (!store_ok) word_cut <= 1'b1;
            if (in_we) begin
              pend_last <= in_te;
              k <= '0;
              rd_pend <= 1'b0;
              if (overflow) state <= ST_PREP;
              else state <= ST_APPND;
            end
          end
        end
        ST_PREP: begin
          // pick the gap widths: last line, lone word, divided padding or single gaps
          pos <= '0; widx <= '0; k <= '0;
          rpart <= '0; dstep <= '0;
          dvd <= room;
          dvr <= CW'(gaps);
          if (last_mode) begin
            quo <= 6'd1; rem <= '0; lone <= 1'b0;
            state <= ST_WORD;
          end else if (gaps == '0) begin
            quo <= '0; rem <= '0; lone <= 1'b1;
            cnt <= (w_eff > chars_in_line) ? room : '0;
            state <= ST_WORD;
          end else if ((w_eff >= chars_in_line) && (room >= CW'(gaps))) begin
            quo <= '0; rem <= '0; lone <= 1'b0;
            state <= ST_DIV;
          end else begin
            // line already wider than the width keeps single gaps
            quo <= 6'd1; rem <= '0; lone <= 1'b0;
            state <= ST_WORD;
          end
        end
        ST_DIV: begin
          rpart <= rp_next;
          quo <= q_next;
          dvd <= {dvd[CW-2:0], 1'b0};
          dstep <= dstep + 3'd1;
          if (dstep == 3'(CW - 1)) begin
            rem <= rp_next;
            state <= ST_WORD;
          end
        end
        ST_WORD: begin
          // line ram read issued at pos; data lands next cycle
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            pos <= pos + 6'd1;
            if (!word_done) begin
              k <= k + 6'd1;
              state <= ST_WORD;
            end else if (widx != gaps) begin
              // leftmost gaps take one extra space while the remainder lasts
              k <= '0;
              widx <= widx + NW'(1);
              cnt <= quo + {{(CW-1){1'b0}}, rem != '0};
              if (rem != '0) rem <= rem - 6'd1;
              state <= ST_SPACE;
            end else if (lone && cnt != '0) begin
              state <= ST_PAD;
            end else begin
              state <= ST_LAST;
            end
          end
        end
        ST_SPACE: begin
          if (out_free) begin
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) state <= ST_WORD;
          end
        end
        ST_PAD: begin
          if (out_free) begin
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) state <= ST_LAST;
          end
        end
        ST_LAST: begin
          // line out: clear, then append word or finish
          chars_in_line <= '0; words_in_line <= '0; trunc_seen <= 1'b0;
          if (last_mode) begin
            last_mode <= 1'b0;
            state <= ST_IDLE;
          end else begin
            k <= '0; rd_pend <= 1'b0;
            state <= ST_APPND;
          end
        end
        ST_APPND: begin
          // copy word ram to line ram; rd_pend marks a read in flight
          if (k < cur_len) begin
            k <= k + 6'd1;
            rd_pend <= 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else begin
            if (words_in_line < NW'(WORDS_MAX)) begin
              lens[words_in_line[LW-1:0]] <= cur_len;
              words_in_line <= words_in_line + NW'(1);
              chars_in_line <= chars_in_line + cur_len;
            end
            trunc_seen <= trunc_seen | word_cut;
            cur_len <= '0; word_cut <= 1'b0;
            if (pend_last) begin
              pend_last <= 1'b0;
              last_mode <= 1'b1;
              state <= ST_PREP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: test/tlj_checker.sv
`timescale 1ns / 1ps
// line checker for the text line justifier: watches the register port and both streams
// keeps its own justification predictor and compares every output transfer; uses tlj_pkg
module tlj_checker
  import tlj_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  localparam int LINE_MAX = 32;
  localparam int WORDS_MAX = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       final_line;
    logic       cut;
  } glyph_t;

  glyph_t     glyph_q[$];
  logic [7:0] line_buf[LINE_MAX];
  logic [7:0] word_buf[LINE_MAX];
  logic [5:0] word_len[WORDS_MAX];
  int         n_words, n_chars, cur_len;
  bit         line_cut, word_cut;
  logic [5:0] width_reg;

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  task automatic push_char(input logic [7:0] ch);
    glyph_t g;
    g.ch = ch;
    g.line_end = 1'b0;
    g.final_line = 1'b0;
    g.cut = line_cut;
    glyph_q = {glyph_q, g};
  endtask

  task automatic push_word(inout int pos, input int idx);
    int k;
    for (k = 0; k < word_len[idx]; k++) begin
      if (pos < LINE_MAX) push_char(line_buf[pos]);
      pos++;
    end
  endtask

  // justified line, or single gaps when it is the last of the text
  task automatic emit_line(input int w, input bit last);
    int pos, gaps, quo, rem, g, k;
    glyph_t tail;
    pos = 0;
    quo = 1;
    rem = 0;
    if (n_words == 0) return;
    gaps = n_words - 1;
    if (!last && gaps == 0) begin
      push_word(pos, 0);
      for (k = n_chars; k < w; k++) push_char(SPACE_CHAR);
    end else begin
      // a line already wider than the width keeps single gaps
      if (!last && w >= n_chars && w - n_chars >= gaps) begin
        quo = (w - n_chars) / gaps;
        rem = (w - n_chars) % gaps;
      end
      for (g = 0; g < gaps; g++) begin
        push_word(pos, g);
        for (k = 0; k < quo; k++) push_char(SPACE_CHAR);
        if (rem > 0) begin
          push_char(SPACE_CHAR);
          rem--;
        end
      end
      push_word(pos, gaps);
    end
    tail = glyph_q.pop_back();
    tail.line_end = 1'b1;
    tail.final_line = last;
    glyph_q = {glyph_q, tail};
  endtask

  task automatic take_char(input logic [7:0] ch, input bit we_in, input bit te);
    int w, k;
    bit we;
    w = eff_width();
    we = we_in | te;
    if (cur_len < w) begin
      word_buf[cur_len] = ch;
      cur_len++;
    end else begin
      word_cut = 1'b1;
    end
    if (!we) return;
    if (n_words > 0 && (n_chars + cur_len + n_words > w || n_words >= WORDS_MAX)) begin
      emit_line(w, 1'b0);
      n_words = 0;
      n_chars = 0;
      line_cut = 1'b0;
    end
    for (k = 0; k < cur_len; k++)
      if (n_chars + k < LINE_MAX) line_buf[n_chars + k] = word_buf[k];
    word_len[n_words] = cur_len[5:0];
    n_words++;
    n_chars += cur_len;
    line_cut |= word_cut;
    cur_len = 0;
    word_cut = 1'b0;
    if (te) begin
      emit_line(w, 1'b1);
      n_words = 0;
      n_chars = 0;
      line_cut = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    glyph_t exp_g;
    if (rst) begin
      glyph_q.delete();
      n_words = 0;
      n_chars = 0;
      cur_len = 0;
      line_cut = 1'b0;
      word_cut = 1'b0;
      width_reg = 6'd32;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_LINE_WIDTH)
        width_reg = pwdata[5:0];
      // predict first so a same-edge output still finds older entries in front
      if (s_axis_tvalid && s_axis_tready)
        take_char(s_axis_tdata, s_axis_tlast, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (glyph_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output transfer: char %02h last %0b user %02b",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          exp_g = glyph_q.pop_front();
          if (m_axis_tdata !== exp_g.ch || m_axis_tlast !== exp_g.line_end ||
              m_axis_tuser[0] !== exp_g.final_line || m_axis_tuser[1] !== exp_g.cut) begin
            fail_count++;
            if (fail_count <= 10)
              $display("output mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                       exp_g.ch, exp_g.line_end, exp_g.final_line, exp_g.cut,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]);
          end
        end
      end
    end
    pending = glyph_q.size();
  end
endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// testbench top for text_line_justifier: clock, reset, stimulus and verdict
// depends on tlj_pkg, the block and tlj_checker (which does all prediction and comparison)
module tb
  import tlj_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;   // character[7:0]
  logic        s_last = 1'b0; // word_end
  logic        s_user = 1'b0; // text_end[0]
  logic        m_ready = 1'b0;
  logic        m_valid;
  logic [7:0]  m_data;        // out_char[7:0]
  logic [1:0]  m_user;        // final_line[0], word_truncated[1]
  logic        m_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = REG_LINE_WIDTH;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  fail_count, pending;
  int  chars_sent = 0;
  bit  quiet = 1'b0;          // no idling on either side in the closing stretch
  int  hold_req = 0, hold_ack = 0;
  int  hold_left = 0, stall_left = 0;

  always #1 clk = ~clk;

  text_line_justifier u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tlast(s_last), .s_axis_tuser(s_user),
    .m_axis_tready(m_ready), .m_axis_tvalid(m_valid), .m_axis_tdata(m_data),
    .m_axis_tuser(m_user), .m_axis_tlast(m_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tlj_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tlast(s_last), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tuser(m_user), .m_axis_tlast(m_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      m_ready <= 1'b0;
      stall_left = $urandom_range(1, 5) - 1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // one character transfer, sometimes after a short sender gap
  task automatic send_char(input logic [7:0] ch, input bit we, input bit te);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= ch;
    s_last <= we;
    s_user <= te;
    do @(posedge clk); while (!s_ready);
    chars_sent++;
  endtask

  // word of random bytes; the text end may come without a word end mark
  task automatic send_word(input int len, input bit te, input bit drop_we);
    int k;
    for (k = 0; k < len - 1; k++) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_char(8'($urandom_range(0, 255)), !(te && drop_we), te);
  endtask

  task automatic reg_write(input logic [5:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_LINE_WIDTH;
    pwdata <= {26'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for every expected character, then give a word copy time to finish
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    int k, nw, w;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default width, seventeen one-letter words hit the word limit per line
    for (k = 0; k < 17; k++) send_char(8'($urandom_range(0, 255)), 1'b1, k == 16);
    // extreme bytes, a space byte, and a text end without a word end
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hff, 1'b0, 1'b0);
    send_char(SPACE_CHAR, 1'b1, 1'b0);
    send_char(8'h7f, 1'b0, 1'b1);
    // overlong word cut to the width
    send_word(35, 1'b1, 1'b0);
    settle();

    // width zero acts as one, widest setting acts as full width
    reg_write(6'd0);
    send_word(1, 1'b0, 1'b0);
    send_word(2, 1'b0, 1'b0);
    send_word(1, 1'b1, 1'b0);
    settle();
    reg_write(6'd63);
    send_word(20, 1'b0, 1'b0);
    send_word(13, 1'b1, 1'b0);
    settle();

    // width shrunk while a line is held: single gaps, then a lone word padded to the width
    reg_write(6'd32);
    send_word(8, 1'b0, 1'b0);
    send_word(8, 1'b0, 1'b0);
    send_word(8, 1'b0, 1'b0);
    settle();
    reg_write(6'd5);
    send_word(2, 1'b0, 1'b0);
    settle();
    reg_write(6'd3);
    send_word(3, 1'b1, 1'b0);
    settle();

    // random texts over a range of widths
    while (chars_sent < 430) begin
      case ($urandom_range(0, 9))
        0: w = 1;
        1: w = 32;
        2: w = 0;
        3: w = 63;
        default: w = $urandom_range(2, 24);
      endcase
      reg_write(w[5:0]);
      if (chars_sent > 150 && hold_req == 0) hold_req = 1;
      if (chars_sent > 360) quiet = 1'b1;
      nw = $urandom_range(3, 12);
      if (w == 0) w = 1;
      if (w > 32) w = 32;
      for (k = 0; k < nw; k++) begin
        if ($urandom_range(0, 9) == 0) send_word($urandom_range(w, w + 4), k == nw - 1,
                                                 $urandom_range(0, 3) == 0);
        else send_word($urandom_range(1, (w < 8) ? w : 8), k == nw - 1,
                       $urandom_range(0, 3) == 0);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: text_line_justifier.f
rtl/tlj_pkg.sv
rtl/tlj_ram.sv
rtl/text_line_justifier.sv
test/tlj_checker.sv
test/tb.sv
